// File: rtl/pdu_header_filter_and_version_patch_macros.svh
// Assertion macros shared by the header filter checker.
`ifndef PDU_HEADER_FILTER_AND_VERSION_PATCH_MACROS_SVH
`define PDU_HEADER_FILTER_AND_VERSION_PATCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PDU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("header filter check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PDU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("header filter check failed");

`endif

// File: rtl/pdu_hf_pkg.sv
// Shared types, constants and codes of the datagram header filter.
package pdu_hf_pkg;

	// Header geometry and derived widths.
	localparam int HEADER_BYTES = 12;
	localparam int IDX_W        = $clog2(HEADER_BYTES);
	localparam int CNT_W        = $clog2(HEADER_BYTES + 1);

	// Field widths.
	localparam int BYTE_W    = 8;
	localparam int NOW_W     = 22;
	localparam int CFG_W     = 22;
	localparam int CFG_IDX_W = 2;
	localparam int TS_W      = 32;
	localparam int CODE_W    = 3;
	localparam int AGE_W     = NOW_W + 1;

	// Timestamp scaling: frame ms = (ts >> 1) * HOUR_MS / 2^31.
	localparam int PROD_W  = (TS_W - 1) + NOW_W;
	localparam int PDU_LSB = 31;
	localparam logic [NOW_W-1:0] HOUR_MS = NOW_W'(3600000);

	// Header byte positions.
	localparam int POS_VERSION  = 0;
	localparam int POS_EXERCISE = 1;
	localparam int POS_TYPE     = 2;
	localparam int POS_TS       = 4;

	// Accepted version range.
	localparam logic [BYTE_W-1:0] VER_MIN = BYTE_W'(5);
	localparam logic [BYTE_W-1:0] VER_MAX = BYTE_W'(7);

	// Register reset values.
	localparam logic [BYTE_W-1:0] RST_TARGET_VERSION = BYTE_W'(7);
	localparam logic [BYTE_W-1:0] RST_EXPECTED_EXER  = BYTE_W'(0);
	localparam logic [NOW_W-1:0]  RST_LATE_THRESHOLD = NOW_W'(1000);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TARGET_VERSION,
		CFG_EXPECTED_EXERCISE,
		CFG_LATE_THRESHOLD
	} cfg_reg_t;

	// Reject reasons; the first failing check wins.
	typedef enum logic [CODE_W-1:0] {
		REJ_NONE,
		REJ_SHORT,
		REJ_VERSION,
		REJ_TYPE,
		REJ_EXERCISE
	} reject_t;

	// Controller states.
	typedef enum logic {
		ST_RECV,
		ST_FLUSH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic             wr_en;      // write the input byte into the header store
		logic [IDX_W-1:0] wr_idx;
		logic             load;       // load the output register
		logic             from_store; // output byte comes from the header store
		logic [IDX_W-1:0] rd_idx;
		logic             patch;      // replace the byte by the target version
		logic             last;       // last item of the frame, carries the verdict
		logic             fin_full;   // the frame held a full header
		logic             use_now_q;  // verdict uses the latched time
		logic             latch_now;  // capture now_ms of the final byte
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free; // output register can take an item this cycle
	} dp_status_t;

endpackage

// File: rtl/pdu_header_filter_and_version_patch.sv
// Top level of the datagram header filter with version patch.
//
// Datagram bytes enter one per item; the first 12 are held in a header store
// and are accepted back to back without waiting on the output. On the twelfth
// byte, or on an earlier final byte, the controller replays the held bytes one
// item per cycle while the output is free (byte 0 replaced by the target version
// for a full header); input is held off until the replay ends. After the header
// each byte is one item in and one item out per cycle while the output is free,
// through a single output register. A frame's last item carries the verdict,
// reject code, lateness flag and seen header fields. Configuration must be
// written via cfg_we, cfg_index, cfg_data while idle; the block does not check.
module pdu_header_filter_and_version_patch import pdu_hf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic                 frame_end,
	input  logic [NOW_W-1:0]     now_ms,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 out_end,
	output logic                 frame_ok,
	output logic [CODE_W-1:0]    reject_code,
	output logic                 frame_late,
	output logic [BYTE_W-1:0]    seen_version,
	output logic [BYTE_W-1:0]    seen_type,
	output logic [BYTE_W-1:0]    seen_exercise,
	output logic [TS_W-1:0]      seen_timestamp
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Sequencing of store writes, flush and pass-through.
	pdu_hf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.frame_end (frame_end),
		.status    (status),
		.cmd       (cmd)
	);

	// Storage, checks and output register.
	pdu_hf_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.data_byte      (data_byte),
		.now_ms         (now_ms),
		.cmd            (cmd),
		.status         (status),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.out_end        (out_end),
		.frame_ok       (frame_ok),
		.reject_code    (reject_code),
		.frame_late     (frame_late),
		.seen_version   (seen_version),
		.seen_type      (seen_type),
		.seen_exercise  (seen_exercise),
		.seen_timestamp (seen_timestamp)
	);

endmodule

// File: rtl/pdu_hf_ctrl.sv
// Controller: byte counting, header flush sequencing and input flow control.
module pdu_hf_ctrl import pdu_hf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       frame_end,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [IDX_W-1:0] rd_q, rd_d;
	logic             end_q, end_d;
	logic             full_q, full_d;

	logic             in_hdr;
	logic             accept;
	logic [CNT_W-1:0] cnt_inc;
	logic             flush_last;

	// State and counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RECV;
			cnt_q   <= '0;
			rd_q    <= '0;
			end_q   <= 1'b0;
			full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			rd_q    <= rd_d;
			end_q   <= end_d;
			full_q  <= full_d;
		end
	end

	assign in_hdr     = cnt_q < CNT_W'(HEADER_BYTES);
	assign cnt_inc    = cnt_q + 1'b1;
	assign flush_last = (CNT_W'(rd_q) + 1'b1) == cnt_q;

	// Header bytes only go into the store; later bytes need the output.
	assign in_ready   = (state_q == ST_RECV) && (in_hdr || status.out_free);
	assign accept     = in_valid && in_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		rd_d    = rd_q;
		end_d   = end_q;
		full_d  = full_q;
		cmd     = '0;
		case (state_q)
			ST_RECV: begin
				if (accept) begin
					if (in_hdr) begin
						cmd.wr_en  = 1'b1;
						cmd.wr_idx = IDX_W'(cnt_q);
						cnt_d      = cnt_inc;
						if (cnt_inc == CNT_W'(HEADER_BYTES) || frame_end) begin
							state_d       = ST_FLUSH;
							rd_d          = '0;
							end_d         = frame_end;
							full_d        = cnt_inc == CNT_W'(HEADER_BYTES);
							cmd.latch_now = frame_end;
						end
					end else begin
						cmd.load     = 1'b1;
						cmd.last     = frame_end;
						cmd.fin_full = 1'b1;
						if (frame_end) begin
							cnt_d = '0;
						end
					end
				end
			end
			ST_FLUSH: begin
				// Replay the held bytes, one item per free output slot.
				if (status.out_free) begin
					cmd.load       = 1'b1;
					cmd.from_store = 1'b1;
					cmd.rd_idx     = rd_q;
					cmd.patch      = full_q && (rd_q == '0);
					cmd.last       = flush_last && end_q;
					cmd.fin_full   = full_q;
					cmd.use_now_q  = 1'b1;
					if (flush_last) begin
						state_d = ST_RECV;
						if (end_q) begin
							cnt_d = '0;
						end
					end else begin
						rd_d = rd_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_RECV;
			end
		endcase
	end

endmodule

// File: rtl/pdu_hf_datapath.sv
// Datapath: configuration, header store, timestamp scaling, verdict and output register.
module pdu_hf_datapath import pdu_hf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic [BYTE_W-1:0]    data_byte,
	input  logic [NOW_W-1:0]     now_ms,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           status,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    out_byte,
	output logic                 out_end,
	output logic                 frame_ok,
	output logic [CODE_W-1:0]    reject_code,
	output logic                 frame_late,
	output logic [BYTE_W-1:0]    seen_version,
	output logic [BYTE_W-1:0]    seen_type,
	output logic [BYTE_W-1:0]    seen_exercise,
	output logic [TS_W-1:0]      seen_timestamp
);

	logic [BYTE_W-1:0] target_version_q;
	logic [BYTE_W-1:0] expected_exercise_q;
	logic [NOW_W-1:0]  late_threshold_q;

	logic [BYTE_W-1:0] store_q [HEADER_BYTES];
	logic [NOW_W-1:0]  now_q;
	logic [PROD_W-1:0] prod_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_end_q;
	logic              frame_ok_q;
	reject_t           code_q;
	logic              late_q;
	logic [BYTE_W-1:0] seen_version_q;
	logic [BYTE_W-1:0] seen_type_q;
	logic [BYTE_W-1:0] seen_exercise_q;
	logic [TS_W-1:0]   seen_ts_q;

	logic [BYTE_W-1:0] hdr_ver;
	logic [BYTE_W-1:0] hdr_exr;
	logic [BYTE_W-1:0] hdr_typ;
	logic [TS_W-1:0]   hdr_ts;
	logic [NOW_W-1:0]  pdu_ms;
	logic [NOW_W-1:0]  now_sel;
	logic [AGE_W-1:0]  age;
	logic              hdr_late;
	reject_t           hdr_code;
	logic [BYTE_W-1:0] byte_sel;

	// Configuration registers; writes to an unused index are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_version_q    <= RST_TARGET_VERSION;
			expected_exercise_q <= RST_EXPECTED_EXER;
			late_threshold_q    <= RST_LATE_THRESHOLD;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TARGET_VERSION:    target_version_q    <= cfg_data[BYTE_W-1:0];
				CFG_EXPECTED_EXERCISE: expected_exercise_q <= cfg_data[BYTE_W-1:0];
				CFG_LATE_THRESHOLD:    late_threshold_q    <= cfg_data[NOW_W-1:0];
				default: ;
			endcase
		end
	end

	// Header store and the latched time of the final byte.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			store_q[cmd.wr_idx] <= data_byte;
		end
		if (cmd.latch_now) begin
			now_q <= now_ms;
		end
	end

	// Header fields at their fixed positions.
	assign hdr_ver = store_q[POS_VERSION];
	assign hdr_exr = store_q[POS_EXERCISE];
	assign hdr_typ = store_q[POS_TYPE];
	assign hdr_ts  = {store_q[POS_TS], store_q[POS_TS+1], store_q[POS_TS+2],
		store_q[POS_TS+3]};

	// Timestamp scaling to ms; the store settles well before any verdict.
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(hdr_ts[TS_W-1:1]) * PROD_W'(HOUR_MS);
	end

	assign pdu_ms  = prod_s1[PDU_LSB +: NOW_W];
	assign now_sel = cmd.use_now_q ? now_q : now_ms;

	// Age with wrap at the hour, then the threshold compare gated by timestamp bit 0.
	always_comb begin
		if (now_sel >= pdu_ms) begin
			age = AGE_W'(now_sel) - AGE_W'(pdu_ms);
		end else begin
			age = AGE_W'(now_sel) + AGE_W'(HOUR_MS) - AGE_W'(pdu_ms);
		end
		hdr_late = hdr_ts[0] && (age > AGE_W'(late_threshold_q));
	end

	// Header checks in priority order.
	always_comb begin
		if (hdr_ver < VER_MIN || hdr_ver > VER_MAX) begin
			hdr_code = REJ_VERSION;
		end else if (hdr_typ == '0) begin
			hdr_code = REJ_TYPE;
		end else if (expected_exercise_q != '0 && hdr_exr != expected_exercise_q) begin
			hdr_code = REJ_EXERCISE;
		end else begin
			hdr_code = REJ_NONE;
		end
	end

	// Byte source for the next item.
	always_comb begin
		if (cmd.patch) begin
			byte_sel = target_version_q;
		end else if (cmd.from_store) begin
			byte_sel = store_q[cmd.rd_idx];
		end else begin
			byte_sel = data_byte;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload; status fields are zero except on the last item.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q      <= byte_sel;
			out_end_q       <= cmd.last;
			frame_ok_q      <= 1'b0;
			code_q          <= REJ_NONE;
			late_q          <= 1'b0;
			seen_version_q  <= '0;
			seen_type_q     <= '0;
			seen_exercise_q <= '0;
			seen_ts_q       <= '0;
			if (cmd.last) begin
				if (cmd.fin_full) begin
					frame_ok_q      <= hdr_code == REJ_NONE;
					code_q          <= hdr_code;
					late_q          <= hdr_late;
					seen_version_q  <= hdr_ver;
					seen_type_q     <= hdr_typ;
					seen_exercise_q <= hdr_exr;
					seen_ts_q       <= hdr_ts;
				end else begin
					code_q <= REJ_SHORT;
				end
			end
		end
	end

	assign status.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign out_end        = out_end_q;
	assign frame_ok       = frame_ok_q;
	assign reject_code    = code_q;
	assign frame_late     = late_q;
	assign seen_version   = seen_version_q;
	assign seen_type      = seen_type_q;
	assign seen_exercise  = seen_exercise_q;
	assign seen_timestamp = seen_ts_q;

endmodule

// File: rtl/pdu_hf_checker.sv
// Port-level checker for the header filter, bound to the top level.
`include "pdu_header_filter_and_version_patch_macros.svh"

module pdu_hf_checker import pdu_hf_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [BYTE_W-1:0]    out_byte,
	input logic                 out_end,
	input logic                 frame_ok,
	input logic [CODE_W-1:0]    reject_code,
	input logic                 frame_late,
	input logic [BYTE_W-1:0]    seen_version,
	input logic [TS_W-1:0]      seen_timestamp
);

	// A stalled item keeps its byte and frame mark.
	`PDU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_end))

	// The verdict flag agrees with the reject code on the last item.
	`PDU_ASSERT_NOW(a_ok_code, out_valid, frame_ok == (out_end && reject_code == REJ_NONE))

	// Items inside a frame carry no status.
	`PDU_ASSERT_NOW(a_mid_clean, out_valid && !out_end, reject_code == REJ_NONE && !frame_late && seen_timestamp == '0)

	// A short frame reports no header fields and is never late.
	`PDU_ASSERT_NOW(a_short_clean, out_valid && out_end && reject_code == REJ_SHORT, !frame_late && seen_version == '0 && seen_timestamp == '0)

endmodule

bind pdu_header_filter_and_version_patch pdu_hf_checker u_pdu_hf_checker (.*);
